>>> rtl/bmf_pkg.sv
package bmf_pkg;

    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int PIX_W      = 24;
    localparam int POS_W      = 10;
    localparam int RESULT_CAP = 8;
    localparam int CAP_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_in_t;

    typedef struct packed {
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
        logic [POS_W-1:0] out_col;
        logic [POS_W-1:0] out_row;
        logic             frame_last;
    } pix_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_SUM,
        ST_WAIT,
        ST_DSTART,
        ST_DIV,
        ST_OUT
    } bmf_state_t;

endpackage

>>> rtl/bmf_line_mem.sv
module bmf_line_mem #(
    parameter int AW    = 14,
    parameter int DEPTH = 15360
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [bmf_pkg::PIX_W-1:0]  wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [bmf_pkg::PIX_W-1:0]  rdata
);
    import bmf_pkg::*;

    logic [PIX_W-1:0] mem [0:DEPTH-1];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bmf_divider.sv
module bmf_divider #(
    parameter int SUM_W = 16,
    parameter int CNT_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] sum_r,
    input  logic [SUM_W-1:0] sum_g,
    input  logic [SUM_W-1:0] sum_b,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [7:0]       quo_r,
    output logic [7:0]       quo_g,
    output logic [7:0]       quo_b
);
    import bmf_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  q_reg   [3];
    logic [CNT_W-1:0]  rem_reg [3];
    logic [SUM_W-1:0]  q_next  [3];
    logic [CNT_W-1:0]  rem_next[3];
    logic [CNT_W-1:0]  div_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    diff;

    always_comb begin
        rem_sh = '0;
        diff   = '0;
        for (int i = 0; i < 3; i++) begin
            rem_sh = {rem_reg[i], q_reg[i][SUM_W-1]};
            diff   = rem_sh - {1'b0, div_reg};
            if (rem_sh >= {1'b0, div_reg}) begin
                rem_next[i] = diff[CNT_W-1:0];
                q_next[i]   = {q_reg[i][SUM_W-2:0], 1'b1};
            end else begin
                rem_next[i] = rem_sh[CNT_W-1:0];
                q_next[i]   = {q_reg[i][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg[0]   <= sum_r;
            q_reg[1]   <= sum_g;
            q_reg[2]   <= sum_b;
            rem_reg[0] <= '0;
            rem_reg[1] <= '0;
            rem_reg[2] <= '0;
            div_reg    <= divisor;
        end else if (busy_reg) begin
            for (int i = 0; i < 3; i++) begin
                q_reg[i]   <= q_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    assign done  = done_reg;
    assign quo_r = q_reg[0][7:0];
    assign quo_g = q_reg[1][7:0];
    assign quo_b = q_reg[2][7:0];

endmodule

>>> rtl/box_mean_filter_top.sv
// Box mean filter over a raster RGB stream, window sums read from the line store.
// Each output takes one line-store read per window pixel, then a
// one-bit-per-cycle divide for all three channels.
// A pixel request keeps s_ready low until every output it releases is computed.
// Reset (aresetn low, synchronous) restores the registers to 1024/1024/2 and clears
// all position counters; the line store is not cleared.
module box_mean_filter_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bmf_pkg::pix_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bmf_pkg::pix_out_t                 m_data
);
    import bmf_pkg::*;

    localparam int SLOTS = 2 * MAX_RADIUS + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = (CW > RW) ? CW : RW;
    localparam int AW    = ((XW > CFG_W) ? XW : CFG_W) + 2;
    localparam int MAW   = SW + CW;
    localparam int DEPTH = SLOTS << CW;
    localparam int CNT_W = $clog2(SLOTS * SLOTS + 1);
    localparam int SUM_W = CNT_W + 8;

    bmf_state_t state_reg, state_next;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [2:0]       radius_reg;

    logic [CW-1:0] in_col_reg, oc_reg, cx_reg, x0_reg, x1_reg;
    logic [RW-1:0] in_row_reg, or_reg, y_reg, ry_reg, y1_reg;
    logic [SW-1:0] in_slot_reg, os_reg, rs_reg;
    logic [CAP_W-1:0] n_reg;
    logic          pix_mode_reg;
    logic          rd_valid_reg;
    logic [SUM_W-1:0] sr_reg, sg_reg, sb_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic          m_valid_reg;
    pix_out_t      m_data_reg;

    logic [AW-1:0] w_eff, h_eff, r_eff, nr_x, nc_x, orow_x, ocol_x;
    logic [AW-1:0] d_r, d_c, y1_x, x1_x;
    logic [SW:0]   start_slot;
    logic          next_ready, pix_more, is_last;
    logic          acc_pixel, acc_drain, mem_we, mem_re;
    logic [PIX_W-1:0] rd_data;
    logic          div_start, div_done;
    logic [7:0]    q_r, q_g, q_b;

    always_comb begin
        if (width_reg == '0) w_eff = AW'(1);
        else if (AW'(width_reg) > AW'(MAX_WIDTH)) w_eff = AW'(MAX_WIDTH);
        else w_eff = AW'(width_reg);
        if (height_reg == '0) h_eff = AW'(1);
        else if (AW'(height_reg) > AW'(MAX_HEIGHT)) h_eff = AW'(MAX_HEIGHT);
        else h_eff = AW'(height_reg);
        if (AW'(radius_reg) > AW'(MAX_RADIUS)) r_eff = AW'(MAX_RADIUS);
        else r_eff = AW'(radius_reg);
    end

    assign orow_x = AW'(or_reg);
    assign ocol_x = AW'(oc_reg);

    always_comb begin
        nr_x = orow_x + r_eff;
        nc_x = ocol_x + r_eff;
        if (nr_x > h_eff - 1'b1) nr_x = h_eff - 1'b1;
        if (nc_x > w_eff - 1'b1) nc_x = w_eff - 1'b1;
        next_ready = (orow_x < h_eff) &&
                     ((nr_x < AW'(in_row_reg)) ||
                      ((nr_x == AW'(in_row_reg)) && (nc_x < AW'(in_col_reg))));
    end

    assign pix_more = (n_reg < CAP_W'(RESULT_CAP)) && (orow_x < h_eff) &&
                      (orow_x + r_eff <= AW'(y_reg)) && next_ready;

    // Window bounds, clipped at the frame edges
    always_comb begin
        d_r  = (orow_x < r_eff) ? orow_x : r_eff;
        d_c  = (ocol_x < r_eff) ? ocol_x : r_eff;
        y1_x = orow_x + r_eff;
        x1_x = ocol_x + r_eff;
        if (y1_x > h_eff - 1'b1) y1_x = h_eff - 1'b1;
        if (x1_x > w_eff - 1'b1) x1_x = w_eff - 1'b1;
        if ({1'b0, os_reg} >= (SW + 1)'(d_r))
            start_slot = {1'b0, os_reg} - (SW + 1)'(d_r);
        else
            start_slot = {1'b0, os_reg} + (SW + 1)'(SLOTS) - (SW + 1)'(d_r);
    end

    assign is_last = (ocol_x == w_eff - 1'b1) && (orow_x == h_eff - 1'b1);

    assign s_ready   = (state_reg == ST_IDLE);
    assign acc_pixel = s_valid && s_ready && (s_data.kind == KIND_PIXEL);
    assign acc_drain = s_valid && s_ready && (s_data.kind == KIND_DRAIN);
    assign mem_we    = acc_pixel && (AW'(in_row_reg) < h_eff);
    assign mem_re    = (state_reg == ST_SUM);

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (mem_we) state_next = ST_CHECK;
                else if (acc_drain && next_ready) state_next = ST_SETUP;
            end
            ST_CHECK:  state_next = pix_more ? ST_SETUP : ST_IDLE;
            ST_SETUP:  state_next = ST_SUM;
            ST_SUM: begin
                if (cx_reg == x1_reg && ry_reg == y1_reg) state_next = ST_WAIT;
            end
            ST_WAIT:   state_next = ST_DSTART;
            ST_DSTART: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg) state_next = pix_mode_reg ? ST_CHECK : ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
        if (cfg_we && cfg_index <= REG_RADIUS) state_next = ST_IDLE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= CFG_W'(1024);
            height_reg   <= CFG_W'(1024);
            radius_reg   <= 3'd2;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            oc_reg       <= '0;
            or_reg       <= '0;
            os_reg       <= '0;
            n_reg        <= '0;
            pix_mode_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= mem_re;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (cfg_we && cfg_index <= REG_RADIUS) begin
                case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_wdata;
                    REG_HEIGHT: height_reg <= cfg_wdata;
                    REG_RADIUS: radius_reg <= cfg_wdata[2:0];
                    default:    ;
                endcase
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                in_slot_reg <= '0;
                oc_reg      <= '0;
                or_reg      <= '0;
                os_reg      <= '0;
            end else begin
                if (mem_we) begin
                    pix_mode_reg <= 1'b1;
                    n_reg        <= '0;
                    if (AW'(in_col_reg) + 1'b1 >= w_eff) begin
                        in_col_reg  <= '0;
                        in_row_reg  <= in_row_reg + 1'b1;
                        in_slot_reg <= (in_slot_reg == SW'(SLOTS - 1)) ? '0
                                                                       : in_slot_reg + 1'b1;
                    end else begin
                        in_col_reg <= in_col_reg + 1'b1;
                    end
                end else if (acc_drain) begin
                    pix_mode_reg <= 1'b0;
                end
                if (state_reg == ST_OUT && !m_valid_reg) begin
                    m_valid_reg <= 1'b1;
                    n_reg       <= n_reg + 1'b1;
                    if (is_last) begin
                        in_col_reg  <= '0;
                        in_row_reg  <= '0;
                        in_slot_reg <= '0;
                        oc_reg      <= '0;
                        or_reg      <= '0;
                        os_reg      <= '0;
                    end else if (ocol_x + 1'b1 >= w_eff) begin
                        oc_reg <= '0;
                        or_reg <= or_reg + 1'b1;
                        os_reg <= (os_reg == SW'(SLOTS - 1)) ? '0 : os_reg + 1'b1;
                    end else begin
                        oc_reg <= oc_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Window walk, accumulation and output register load
    always_ff @(posedge aclk) begin
        if (mem_we) y_reg <= in_row_reg;
        if (state_reg == ST_SETUP) begin
            x0_reg  <= CW'(ocol_x - d_c);
            cx_reg  <= CW'(ocol_x - d_c);
            x1_reg  <= CW'(x1_x);
            ry_reg  <= RW'(orow_x - d_r);
            y1_reg  <= RW'(y1_x);
            rs_reg  <= start_slot[SW-1:0];
            sr_reg  <= '0;
            sg_reg  <= '0;
            sb_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (state_reg == ST_SUM) begin
                if (cx_reg == x1_reg) begin
                    cx_reg <= x0_reg;
                    ry_reg <= ry_reg + 1'b1;
                    rs_reg <= (rs_reg == SW'(SLOTS - 1)) ? '0 : rs_reg + 1'b1;
                end else begin
                    cx_reg <= cx_reg + 1'b1;
                end
            end
            if (rd_valid_reg) begin
                sr_reg  <= sr_reg + SUM_W'(rd_data[23:16]);
                sg_reg  <= sg_reg + SUM_W'(rd_data[15:8]);
                sb_reg  <= sb_reg + SUM_W'(rd_data[7:0]);
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (state_reg == ST_OUT && !m_valid_reg) begin
            m_data_reg.out_red    <= q_r;
            m_data_reg.out_green  <= q_g;
            m_data_reg.out_blue   <= q_b;
            m_data_reg.out_col    <= POS_W'(oc_reg);
            m_data_reg.out_row    <= POS_W'(or_reg);
            m_data_reg.frame_last <= is_last;
        end
    end

    bmf_line_mem #(
        .AW    (MAW),
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr ({in_slot_reg, in_col_reg}),
        .wdata ({s_data.red, s_data.green, s_data.blue}),
        .re    (mem_re),
        .raddr ({rs_reg, cx_reg}),
        .rdata (rd_data)
    );

    bmf_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sum_r   (sr_reg),
        .sum_g   (sg_reg),
        .sum_b   (sb_reg),
        .divisor (cnt_reg),
        .done    (div_done),
        .quo_r   (q_r),
        .quo_g   (q_g),
        .quo_b   (q_b)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_cnt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DSTART |-> cnt_reg != '0)
        else $error("divide started with an empty window");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !m_valid_reg && !(cfg_we && cfg_index <= REG_RADIUS))
        |=> m_valid_reg)
        else $error("result not loaded into the output register");
`endif

endmodule
